// ===== rtl/core/ioe_pkg.sv =====
// Shared types and constants of the image orientation engine.
package ioe_pkg;

   // Field widths fixed by the register map and the coordinate range.
   localparam int MODE_W     = 3;
   localparam int DIM_W      = 7;
   localparam int COORD_W    = 7;
   localparam int PROD_W     = 2 * DIM_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   // Orientation modes.
   localparam logic [MODE_W-1:0] MODE_CW    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_CCW   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_HMIR  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_VMIR  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_TRANS = 3'd4;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd2;

   // Register reset values.
   localparam logic [MODE_W-1:0] MODE_RESET = MODE_CW;
   localparam logic [DIM_W-1:0]  DIM_RESET  = 7'd64;

   // Input beat kinds carried on tuser.
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_FETCH = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // store the accepted pixel
      logic fetch;  // latch the source position of the accepted fetch
      logic calc;   // form the store address
      logic read;   // read the store
      logic push;   // move the result into the output register
   } ioe_cmd_type;

endpackage

// ===== rtl/core/ioe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ioe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/ioe_ctrl.sv =====
// Controller state machine that sequences loads and fetches.
module ioe_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tuser,
   output logic                req_tready,
   input  logic                out_free,
   output ioe_pkg::ioe_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_READ,
      ST_PUSH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load  = accept && (req_tuser == ioe_pkg::CMD_LOAD);
            cmd.fetch = accept && (req_tuser == ioe_pkg::CMD_FETCH);
            if (cmd.fetch) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (out_free) begin
               cmd.push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/ioe_datapath.sv =====
// Datapath: registers, frame counters, address generation and frame store.
module ioe_datapath #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64,
   parameter int PIXEL_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ioe_pkg::ioe_cmd_type               cmd,
   output logic                               out_free,
   input  logic [PIXEL_BITS-1:0]              pixel_in,
   input  logic                               csr_valid,
   input  logic [ioe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ioe_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [PIXEL_BITS-1:0]              pixel_out,
   output logic                               frame_last,
   output logic                               underrun
);

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int LOAD_W = $clog2(DEPTH + 1);
   localparam int CMP_W  = (LOAD_W > ioe_pkg::PROD_W) ? LOAD_W : ioe_pkg::PROD_W;
   localparam int DW     = ioe_pkg::DIM_W;
   localparam int CW     = ioe_pkg::COORD_W;

   // Configuration registers.
   logic [ioe_pkg::MODE_W-1:0] mode_ff;
   logic [DW-1:0]              width_ff;
   logic [DW-1:0]              height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= ioe_pkg::MODE_RESET;
         width_ff  <= ioe_pkg::DIM_RESET;
         height_ff <= ioe_pkg::DIM_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            ioe_pkg::CSR_MODE:   mode_ff   <= csr_data[ioe_pkg::MODE_W-1:0];
            ioe_pkg::CSR_WIDTH:  width_ff  <= csr_data[DW-1:0];
            ioe_pkg::CSR_HEIGHT: height_ff <= csr_data[DW-1:0];
            default: ;
         endcase
      end
   end

   // Effective dimensions: zero acts as one, large values saturate.
   logic [DW-1:0]                dim_w, dim_h, out_w, out_h;
   logic [ioe_pkg::PROD_W-1:0]   total;
   logic                         swap;

   always_comb begin
      if (width_ff == '0) begin
         dim_w = DW'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         dim_w = DW'(MAX_WIDTH);
      end else begin
         dim_w = width_ff;
      end
      if (height_ff == '0) begin
         dim_h = DW'(1);
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         dim_h = DW'(MAX_HEIGHT);
      end else begin
         dim_h = height_ff;
      end
      total = ioe_pkg::PROD_W'(dim_w) * ioe_pkg::PROD_W'(dim_h);
      swap  = (mode_ff == ioe_pkg::MODE_CW) || (mode_ff == ioe_pkg::MODE_CCW)
           || (mode_ff == ioe_pkg::MODE_TRANS);
      out_w = swap ? dim_h : dim_w;
      out_h = swap ? dim_w : dim_h;
   end

   // Frame state.
   logic [LOAD_W-1:0] load_count_ff, load_count_in, load_base, load_next;
   logic              frame_ready_ff, frame_ready_in;
   logic [CW-1:0]     out_col_ff, out_col_in, out_row_ff, out_row_in;
   logic [CW-1:0]     pos_x, pos_y, src_c, src_r;
   logic              wrap, is_last;
   logic              wr_en;

   // Load counting and output raster stepping.
   always_comb begin
      load_count_in  = load_count_ff;
      frame_ready_in = frame_ready_ff;
      out_col_in     = out_col_ff;
      out_row_in     = out_row_ff;

      load_base = frame_ready_ff ? '0 : load_count_ff;
      load_next = load_base + LOAD_W'(1);
      wr_en     = cmd.load && (int'(load_base) < DEPTH);

      // A position beyond the current output size restarts the frame.
      wrap  = (out_col_ff >= out_w) || (out_row_ff >= out_h);
      pos_x = wrap ? '0 : out_col_ff;
      pos_y = wrap ? '0 : out_row_ff;

      unique case (mode_ff)
         ioe_pkg::MODE_CW: begin
            src_c = pos_y;
            src_r = dim_h - DW'(1) - pos_x;
         end
         ioe_pkg::MODE_CCW: begin
            src_c = dim_w - DW'(1) - pos_y;
            src_r = pos_x;
         end
         ioe_pkg::MODE_HMIR: begin
            src_c = dim_w - DW'(1) - pos_x;
            src_r = pos_y;
         end
         ioe_pkg::MODE_VMIR: begin
            src_c = pos_x;
            src_r = dim_h - DW'(1) - pos_y;
         end
         ioe_pkg::MODE_TRANS: begin
            src_c = pos_y;
            src_r = pos_x;
         end
         default: begin
            src_c = pos_x;
            src_r = pos_y;
         end
      endcase

      is_last = (pos_x == out_w - DW'(1)) && (pos_y == out_h - DW'(1));

      if (cmd.load) begin
         load_count_in  = load_next;
         frame_ready_in = 1'b0;
         if (CMP_W'(load_next) >= CMP_W'(total)) begin
            frame_ready_in = 1'b1;
            out_col_in     = '0;
            out_row_in     = '0;
         end
      end else if (cmd.fetch && frame_ready_ff) begin
         if (pos_x + CW'(1) < out_w) begin
            out_col_in = pos_x + CW'(1);
            out_row_in = pos_y;
         end else begin
            out_col_in = '0;
            out_row_in = (pos_y + CW'(1) < out_h) ? pos_y + CW'(1) : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff  <= '0;
         frame_ready_ff <= 1'b0;
         out_col_ff     <= '0;
         out_row_ff     <= '0;
      end else begin
         load_count_ff  <= load_count_in;
         frame_ready_ff <= frame_ready_in;
         out_col_ff     <= out_col_in;
         out_row_ff     <= out_row_in;
      end
   end

   // Fetch pipeline: source position, then address, then store read.
   logic [CW-1:0]     src_c_ff, src_r_ff;
   logic              last_ff, under_ff;
   logic [ADDR_W-1:0] rd_addr_ff;
   logic [ioe_pkg::PROD_W-1:0] addr_sum;

   assign addr_sum = ioe_pkg::PROD_W'(src_r_ff) * ioe_pkg::PROD_W'(dim_w)
                   + ioe_pkg::PROD_W'(src_c_ff);

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         src_c_ff <= src_c;
         src_r_ff <= src_r;
         last_ff  <= frame_ready_ff && is_last;
         under_ff <= !frame_ready_ff;
      end
      if (cmd.calc) begin
         rd_addr_ff <= ADDR_W'(addr_sum);
      end
   end

   // Frame store.
   logic [PIXEL_BITS-1:0] rd_data;

   ioe_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (load_base[ADDR_W-1:0]),
      .wr_data (pixel_in),
      .rd_en   (cmd.read),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   // Output register; it holds a beat until the consumer takes it.
   logic                  rsp_valid_ff;
   logic [PIXEL_BITS-1:0] rsp_pixel_ff;
   logic                  rsp_last_ff, rsp_under_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_pixel_ff <= under_ff ? '0 : rd_data;
         rsp_last_ff  <= last_ff;
         rsp_under_ff <= under_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign pixel_out  = rsp_pixel_ff;
   assign frame_last = rsp_last_ff;
   assign underrun   = rsp_under_ff;

endmodule

// ===== rtl/core/image_orientation_engine_core.sv =====
// Top level of the image orientation engine: frame store with reorienting readout.
//
//  Channel | Direction | Handshake             | Payload
//  req     | in        | req_tvalid/req_tready | tdata: pixel_in; tuser: cmd
//  rsp     | out       | rsp_tvalid/rsp_tready | tdata: pixel_out; tlast; tuser: underrun
//  csr     | in        | csr_valid/csr_ready   | csr_index, csr_data
//
// A load beat writes the pixel to the frame store at once.
// A fetch beat passes through four steps: source position, address multiply, store
// read and the move into the output register; the store's read data is registered.
// Reset is synchronous and active high; the store contents are not cleared.
// A full output register holds back a fetch only at its last step.
module image_orientation_engine_core #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64,
   parameter int PIXEL_BITS = 32
) (
   input  logic                                       clock,
   input  logic                                       reset,
   // Input beats.
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   input  logic [((PIXEL_BITS + 7) / 8) * 8 - 1:0]    req_tdata,  // pixel_in
   input  logic                                       req_tuser,  // cmd
   // Result beats.
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   output logic [((PIXEL_BITS + 7) / 8) * 8 - 1:0]    rsp_tdata,  // pixel_out
   output logic                                       rsp_tlast,
   output logic                                       rsp_tuser,  // underrun
   // Register writes.
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [ioe_pkg::CSR_IDX_W-1:0]              csr_index,
   input  logic [ioe_pkg::CSR_DATA_W-1:0]             csr_data
);

   localparam int TDATA_W = ((PIXEL_BITS + 7) / 8) * 8;

   ioe_pkg::ioe_cmd_type  cmd;
   logic                  out_free;
   logic [PIXEL_BITS-1:0] pixel_out;

   assign csr_ready = 1'b1;

   ioe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .out_free   (out_free),
      .cmd        (cmd)
   );

   ioe_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .out_free   (out_free),
      .pixel_in   (req_tdata[PIXEL_BITS-1:0]),
      .csr_valid  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .pixel_out  (pixel_out),
      .frame_last (rsp_tlast),
      .underrun   (rsp_tuser)
   );

   assign rsp_tdata = TDATA_W'(pixel_out);

   // An underrun beat is never the last of a frame.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tlast)
      else $error("underrun beat flagged as last");

   // A fetch occupies the engine for the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> !req_tready)
      else $error("input accepted during a fetch");

   // A load never produces a result beat.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser |=> !$rose(rsp_tvalid))
      else $error("result beat after a load");

   // An underrun result carries a zero pixel.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (pixel_out == '0))
      else $error("underrun beat with nonzero pixel");

endmodule
